// ===== rtl/line_follow_pid_steering_core_macros.svh =====
// ---------------------------------------------------------------------------
// Line follower PID steering core: assertion macros
// Concurrent property wrappers shared by the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_STEERING_CORE_MACROS_SVH
`define LINE_FOLLOW_PID_STEERING_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define LFPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define LFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfps_pkg.sv =====
// ---------------------------------------------------------------------------
// Line follower PID steering package
// Widths, register map, reset values and small lookup functions.
// ---------------------------------------------------------------------------
package lfps_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int NUM_SENSORS = 5;
  localparam int THR_W       = 10;
  localparam int CMP_W       = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int SPEED_W     = 8;
  localparam int GAIN_W      = 16;
  localparam int ILIM_W      = 7;
  localparam int SLIM_W      = 8;
  localparam int POS_W       = 6;
  localparam int INT_W       = 8;
  localparam int ISUM_W      = 9;
  localparam int DIF_W       = 7;
  localparam int TERM_W      = 9;
  localparam int ACC_W       = 25;
  localparam int FRAC_BITS   = 12;
  localparam int HI_W        = ACC_W - FRAC_BITS;
  localparam int SPD_W       = 10;
  localparam int DUTY_W      = 8;
  localparam int CNT_W       = $clog2(GAIN_W);
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 3;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  localparam logic [THR_W-1:0]   RST_THRESHOLD  = 10'd512;
  localparam logic [SPEED_W-1:0] RST_BASE_SPEED = 8'd200;
  localparam logic [GAIN_W-1:0]  RST_GAIN_P     = 16'd8192;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I     = 16'd82;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D     = 16'd6144;
  localparam logic [ILIM_W-1:0]  RST_INT_LIMIT  = 7'd100;
  localparam logic [SLIM_W-1:0]  RST_STEER_LIM  = 8'd100;

  typedef enum logic [IDX_W-1:0] {
    REG_LINE_THRESHOLD = 3'd0,
    REG_BASE_SPEED     = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_INT_LIMIT      = 3'd5,
    REG_STEER_LIMIT    = 3'd6
  } lfps_reg_e;

  typedef struct packed {
    logic              forward;
    logic [DUTY_W-1:0] duty;
  } side_t;

  // Centroid of the hit mask (bit 0 is the far left sensor), scaled by ten,
  // truncated toward zero. Zero when there are no hits.
  function automatic logic signed [POS_W-1:0] pos_of_mask(
    input logic [NUM_SENSORS-1:0] mask
  );
    logic [2:0]              hits;
    logic signed [3:0]       wsum;
    logic [1:0]              k;
    logic [4:0]              mag;
    logic signed [POS_W-1:0] pos;
    hits = '0;
    wsum = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (mask[i]) begin
        hits = hits + 3'd1;
        wsum = wsum + 4'(i - 2);
      end
    end
    k = wsum[3] ? 2'(-wsum) : 2'(wsum);
    case ({hits, k})
      {3'd1, 2'd1}: mag = 5'd10;
      {3'd1, 2'd2}: mag = 5'd20;
      {3'd1, 2'd3}: mag = 5'd30;
      {3'd2, 2'd1}: mag = 5'd5;
      {3'd2, 2'd2}: mag = 5'd10;
      {3'd2, 2'd3}: mag = 5'd15;
      {3'd3, 2'd1}: mag = 5'd3;
      {3'd3, 2'd2}: mag = 5'd6;
      {3'd3, 2'd3}: mag = 5'd10;
      {3'd4, 2'd1}: mag = 5'd2;
      {3'd4, 2'd2}: mag = 5'd5;
      {3'd4, 2'd3}: mag = 5'd7;
      {3'd5, 2'd1}: mag = 5'd2;
      {3'd5, 2'd2}: mag = 5'd4;
      {3'd5, 2'd3}: mag = 5'd6;
      default:      mag = 5'd0;
    endcase
    pos = {1'b0, mag};
    return wsum[3] ? -pos : pos;
  endfunction

  // Direction bit and saturated duty for one side's signed speed
  function automatic side_t side_of(input logic [SPD_W-1:0] spd);
    logic [SPD_W-1:0] mag;
    side_t            res;
    mag         = spd[SPD_W-1] ? -spd : spd;
    res.forward = ~spd[SPD_W-1];
    res.duty    = (mag > SPD_W'(DUTY_MAX)) ? DUTY_MAX : mag[DUTY_W-1:0];
    return res;
  endfunction

endpackage

// ===== rtl/line_follow_pid_steering_core.sv =====
// ---------------------------------------------------------------------------
// Line follower PID steering core
// Steps per request: error, 16-step bit-serial gain multiply (one gain
// bit of each term per cycle), clamp, then the output register once it is
// free. A new request is taken only after the last has left the done step.
// Reset clears the PID state and loads the register reset values at once.
// ---------------------------------------------------------------------------
`include "line_follow_pid_steering_core_macros.svh"

module line_follow_pid_steering_core
  import lfps_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample request
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_far_left_i,
  input  logic [SAMPLE_BITS-1:0] sample_left_i,
  input  logic [SAMPLE_BITS-1:0] sample_center_i,
  input  logic [SAMPLE_BITS-1:0] sample_right_i,
  input  logic [SAMPLE_BITS-1:0] sample_far_right_i,
  // drive result
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   left_forward_o,
  output logic [DUTY_W-1:0]      left_duty_o,
  output logic                   right_forward_o,
  output logic [DUTY_W-1:0]      right_duty_o,
  output logic signed [POS_W-1:0] line_position_o,
  output logic                   line_found_o,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_CLAMP,
    ST_DONE
  } state_e;

  // registers
  logic [THR_W-1:0]   threshold_q;
  logic [SPEED_W-1:0] base_speed_q;
  logic [GAIN_W-1:0]  gain_p_q;
  logic [GAIN_W-1:0]  gain_i_q;
  logic [GAIN_W-1:0]  gain_d_q;
  logic [ILIM_W-1:0]  int_limit_q;
  logic [SLIM_W-1:0]  steer_limit_q;

  logic [IDX_W-1:0]   reg_idx;
  logic               reg_wr;

  state_e                   state_q;
  logic [NUM_SENSORS-1:0]   mask_q;
  logic                     found_q;
  logic signed [POS_W-1:0]  prev_q;
  logic signed [INT_W-1:0]  integral_q;
  logic signed [DIF_W-1:0]  dif_q;
  logic [GAIN_W-1:0]        gp_sh_q;
  logic [GAIN_W-1:0]        gi_sh_q;
  logic [GAIN_W-1:0]        gd_sh_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     steer_neg_q;
  logic [SLIM_W-1:0]        steer_mag_q;
  logic                     out_valid_q;
  side_t                    left_q;
  side_t                    right_q;
  logic signed [POS_W-1:0]  pos_out_q;
  logic                     found_out_q;

  logic [NUM_SENSORS-1:0]   mask_d;
  logic signed [POS_W-1:0]  err_d;
  logic signed [ISUM_W-1:0] isum;
  logic signed [ISUM_W-1:0] ilim;
  logic signed [ISUM_W-1:0] ilim_n;
  logic signed [ISUM_W-1:0] iclamp;
  logic signed [INT_W-1:0]  integral_d;
  logic signed [DIF_W-1:0]  dif_d;
  logic signed [TERM_W-1:0] term_p;
  logic signed [TERM_W-1:0] term_i;
  logic signed [TERM_W-1:0] term_d;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_d;
  logic [ACC_W-1:0]         acc_mag;
  logic [HI_W-1:0]          acc_hi;
  logic [SLIM_W-1:0]        steer_mag_d;
  logic [SPD_W-1:0]         steer_spd;
  logic [SPD_W-1:0]         left_spd;
  logic [SPD_W-1:0]         right_spd;

  // -------------------------------------------------------------------------
  // register port
  // -------------------------------------------------------------------------
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= RST_THRESHOLD;
      base_speed_q  <= RST_BASE_SPEED;
      gain_p_q      <= RST_GAIN_P;
      gain_i_q      <= RST_GAIN_I;
      gain_d_q      <= RST_GAIN_D;
      int_limit_q   <= RST_INT_LIMIT;
      steer_limit_q <= RST_STEER_LIM;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_LINE_THRESHOLD: threshold_q   <= pwdata[THR_W-1:0];
        REG_BASE_SPEED:     base_speed_q  <= pwdata[SPEED_W-1:0];
        REG_GAIN_P:         gain_p_q      <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:         gain_i_q      <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:         gain_d_q      <= pwdata[GAIN_W-1:0];
        REG_INT_LIMIT:      int_limit_q   <= pwdata[ILIM_W-1:0];
        REG_STEER_LIMIT:    steer_limit_q <= pwdata[SLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LINE_THRESHOLD: prdata = DATA_W'(threshold_q);
      REG_BASE_SPEED:     prdata = DATA_W'(base_speed_q);
      REG_GAIN_P:         prdata = DATA_W'(gain_p_q);
      REG_GAIN_I:         prdata = DATA_W'(gain_i_q);
      REG_GAIN_D:         prdata = DATA_W'(gain_d_q);
      REG_INT_LIMIT:      prdata = DATA_W'(int_limit_q);
      REG_STEER_LIMIT:    prdata = DATA_W'(steer_limit_q);
      default:            prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // datapath
  // -------------------------------------------------------------------------
  always_comb begin
    mask_d[0] = CMP_W'(sample_far_left_i)  < CMP_W'(threshold_q);
    mask_d[1] = CMP_W'(sample_left_i)      < CMP_W'(threshold_q);
    mask_d[2] = CMP_W'(sample_center_i)    < CMP_W'(threshold_q);
    mask_d[3] = CMP_W'(sample_right_i)     < CMP_W'(threshold_q);
    mask_d[4] = CMP_W'(sample_far_right_i) < CMP_W'(threshold_q);

    // no hits: hold the previous error
    err_d = found_q ? pos_of_mask(mask_q) : prev_q;

    isum   = {integral_q[INT_W-1], integral_q}
           + {{(ISUM_W-POS_W){err_d[POS_W-1]}}, err_d};
    ilim   = {{(ISUM_W-ILIM_W){1'b0}}, int_limit_q};
    ilim_n = -ilim;
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < ilim_n) begin
      iclamp = ilim_n;
    end else begin
      iclamp = isum;
    end
    integral_d = iclamp[INT_W-1:0];

    dif_d = {err_d[POS_W-1], err_d} - {prev_q[POS_W-1], prev_q};

    // one gain bit of each term per cycle, MSB first
    term_p = gp_sh_q[GAIN_W-1] ? {{(TERM_W-POS_W){prev_q[POS_W-1]}}, prev_q} : '0;
    term_i = gi_sh_q[GAIN_W-1] ? {{(TERM_W-INT_W){integral_q[INT_W-1]}}, integral_q} : '0;
    term_d = gd_sh_q[GAIN_W-1] ? {{(TERM_W-DIF_W){dif_q[DIF_W-1]}}, dif_q} : '0;
    term   = term_p + term_i + term_d;
    acc_d  = {acc_q[ACC_W-2:0], 1'b0} + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};

    // clamping the magnitude before the shift equals clamping the shifted value
    acc_mag     = acc_q[ACC_W-1] ? -acc_q : acc_q;
    acc_hi      = acc_mag[ACC_W-1:FRAC_BITS];
    steer_mag_d = (acc_hi > HI_W'(steer_limit_q)) ? steer_limit_q : acc_hi[SLIM_W-1:0];

    steer_spd = steer_neg_q ? -SPD_W'(steer_mag_q) : SPD_W'(steer_mag_q);
    left_spd  = SPD_W'(base_speed_q) - steer_spd;
    right_spd = SPD_W'(base_speed_q) + steer_spd;
  end

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= '0;
      found_q     <= 1'b0;
      prev_q      <= '0;
      integral_q  <= '0;
      dif_q       <= '0;
      gp_sh_q     <= '0;
      gi_sh_q     <= '0;
      gd_sh_q     <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      steer_neg_q <= 1'b0;
      steer_mag_q <= '0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      pos_out_q   <= '0;
      found_out_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mask_q  <= mask_d;
            found_q <= |mask_d;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          prev_q     <= err_d;
          integral_q <= integral_d;
          dif_q      <= dif_d;
          gp_sh_q    <= gain_p_q;
          gi_sh_q    <= gain_i_q;
          gd_sh_q    <= gain_d_q;
          acc_q      <= '0;
          cnt_q      <= CNT_W'(GAIN_W - 1);
          state_q    <= ST_MUL;
        end
        ST_MUL: begin
          acc_q   <= acc_d;
          gp_sh_q <= {gp_sh_q[GAIN_W-2:0], 1'b0};
          gi_sh_q <= {gi_sh_q[GAIN_W-2:0], 1'b0};
          gd_sh_q <= {gd_sh_q[GAIN_W-2:0], 1'b0};
          if (cnt_q == '0) begin
            state_q <= ST_CLAMP;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_CLAMP: begin
          steer_neg_q <= acc_q[ACC_W-1];
          steer_mag_q <= steer_mag_d;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          // wait for the output register to drain
          if (!out_valid_q || out_ready_i) begin
            left_q      <= side_of(left_spd);
            right_q     <= side_of(right_spd);
            pos_out_q   <= prev_q;
            found_out_q <= found_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign left_forward_o  = left_q.forward;
  assign left_duty_o     = left_q.duty;
  assign right_forward_o = right_q.forward;
  assign right_duty_o    = right_q.duty;
  assign line_position_o = pos_out_q;
  assign line_found_o    = found_out_q;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `LFPS_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_ERR, "accepted request did not start the error step")
  `LFPS_ASSERT_NEXT(a_mul_ends, clk_i, rst_ni, state_q == ST_MUL && cnt_q == '0, state_q == ST_CLAMP, "multiply did not end after the last gain bit")
  `LFPS_ASSERT_SAME(a_gains_drained, clk_i, rst_ni, state_q == ST_CLAMP, gp_sh_q == '0 && gi_sh_q == '0 && gd_sh_q == '0, "gain bits left unconsumed")
  `LFPS_ASSERT_SAME(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE, "result raised outside the done step")

endmodule
